FILE: rtl/rrts_pkg.sv
// Shared types and constants of the round-robin time-slice scheduler.
`default_nettype none
package rrts_pkg;

  localparam int DEFAULT_MAX_PROCS = 16;
  localparam int ID_W              = 16;
  localparam int TIME_W            = 16;
  localparam int STATUS_W          = 3;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(1);
  localparam logic [ID_W-1:0]   NEXT_ID_RESET = ID_W'(1);

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RAN       = 3'd0,
    ST_COMPLETED = 3'd1,
    ST_ADDED     = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_IDLE      = 3'd4
  } status_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/rrts_in_if.sv
// Input channel of the scheduler: command and execution time.
`default_nettype none
interface rrts_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [rrts_pkg::TIME_W-1:0] exec_time;

  modport source (output valid, output func, output exec_time, input ready);
  modport sink   (input valid, input func, input exec_time, output ready);
endinterface
`default_nettype wire

FILE: rtl/rrts_out_if.sv
// Result channel of scheduler: one report per process or command.
`default_nettype none
interface rrts_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::ID_W-1:0]     proc_id;
  logic [rrts_pkg::TIME_W-1:0]   remaining;
  logic [rrts_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (output valid, output proc_id, output remaining, output status,
                  output last, input ready);
  modport sink   (input valid, input proc_id, input remaining, input status,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/rrts_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/round_robin_time_slice_scheduler.sv
// Round-robin time-slice scheduler: process table in RAM, one round per run command.
//
// The table of up to MAX_PROCS processes (id and remaining time) lives in a single
// simple dual-port RAM. An add command appends at the tail and answers in the next
// cycle; a full table or a run on an empty table also answers with a single result.
// A run command walks the table from head to tail, one entry per cycle through the
// RAM read port while the result channel accepts, and compacts survivors in place
// through the write port; each entry passes the registered RAM read and then the
// result register. A new command is taken once the previous one has issued all its
// results; the result register lets it be taken in the same cycle that the last result
// is accepted, but not while that result is stalled. The quantum register may be
// written only while the block is idle.
`default_nettype none
module round_robin_time_slice_scheduler #(
  parameter int MAX_PROCS = rrts_pkg::DEFAULT_MAX_PROCS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rrts_in_if.sink                          in_ch,
  rrts_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [rrts_pkg::TIME_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_PROCS);     // table index width
  localparam int CW = $clog2(MAX_PROCS + 1); // count width
  localparam int EW = $bits(rrts_pkg::entry_t);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 occ_r, occ_nxt;
  logic [rrts_pkg::ID_W-1:0]     next_id_r, next_id_nxt;
  logic [rrts_pkg::TIME_W-1:0]   quantum_r;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 keep_r, keep_nxt;
  logic [CW-1:0]                 total_r, total_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [rrts_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [rrts_pkg::TIME_W-1:0]   out_rem_r, out_rem_nxt;
  rrts_pkg::status_t             out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          ram_we, ram_re;
  logic [IW-1:0]                 ram_waddr, ram_raddr;
  rrts_pkg::entry_t              ram_wentry, ram_rentry;
  logic [EW-1:0]                 ram_rdata;

  logic                          can_load;
  logic                          in_fire;
  logic [rrts_pkg::TIME_W:0]     diff;
  logic                          survives;
  logic                          at_end;

  rrts_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_rentry = rrts_pkg::entry_t'(ram_rdata);

  assign can_load    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && can_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // remaining > quantum exactly when the subtraction neither borrows nor hits zero
  assign diff     = {1'b0, ram_rentry.rem} - {1'b0, quantum_r};
  assign survives = !diff[rrts_pkg::TIME_W] && (diff[rrts_pkg::TIME_W-1:0] != '0);
  assign at_end   = (CW'(idx_r) + CW'(1)) == total_r;

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    next_id_nxt    = next_id_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_id_nxt     = out_id_r;
    out_rem_nxt    = out_rem_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = occ_r[IW-1:0];
    ram_wentry     = '{id: next_id_r, rem: in_ch.exec_time};
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_id_nxt    = '0;
          out_rem_nxt   = '0;
          if (in_ch.func == rrts_pkg::FUNC_ADD) begin
            if (occ_r == FULL_CNT) begin
              out_status_nxt = rrts_pkg::ST_REJECTED;
            end else begin
              ram_we         = 1'b1;
              occ_nxt        = occ_r + CW'(1);
              next_id_nxt    = next_id_r + rrts_pkg::ID_W'(1);
              out_id_nxt     = next_id_r;
              out_rem_nxt    = in_ch.exec_time;
              out_status_nxt = rrts_pkg::ST_ADDED;
            end
          end else if (occ_r == '0) begin
            out_status_nxt = rrts_pkg::ST_IDLE;
          end else begin
            // start the round: first read now, results once its data leaves the RAM read register
            out_valid_nxt = 1'b0;
            ram_re        = 1'b1;
            ram_raddr     = '0;
            idx_nxt       = '0;
            keep_nxt      = '0;
            total_nxt     = occ_r;
            state_nxt     = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = ram_rentry.id;
          out_last_nxt  = at_end;
          if (survives) begin
            out_rem_nxt    = diff[rrts_pkg::TIME_W-1:0];
            out_status_nxt = rrts_pkg::ST_RAN;
            // compaction: keep never passes the read pointer
            ram_we         = 1'b1;
            ram_waddr      = keep_r[IW-1:0];
            ram_wentry     = '{id: ram_rentry.id, rem: diff[rrts_pkg::TIME_W-1:0]};
            keep_nxt       = keep_r + CW'(1);
          end else begin
            out_rem_nxt    = '0;
            out_status_nxt = rrts_pkg::ST_COMPLETED;
          end
          if (at_end) begin
            occ_nxt   = survives ? keep_r + CW'(1) : keep_r;
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + IW'(1);
            idx_nxt   = idx_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      next_id_r   <= rrts_pkg::NEXT_ID_RESET;
      quantum_r   <= rrts_pkg::QUANTUM_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      keep_r      <= '0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      total_r     <= total_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_id_r     <= out_id_nxt;
    out_rem_r    <= out_rem_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.proc_id   = out_id_r;
  assign out_ch.remaining = out_rem_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy exceeds table depth");

  a_run_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (total_r != '0) && (CW'(idx_r) < total_r)
                           && (keep_r <= CW'(idx_r)))
    else $error("round pointers out of order");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.func == rrts_pkg::FUNC_ADD) && (occ_r != FULL_CNT))
      |=> (occ_r == $past(occ_r) + CW'(1)) && (next_id_r == $past(next_id_r) + 16'd1))
    else $error("add did not grow the table");
`endif

endmodule
`default_nettype wire
